FILE: rtl/gzf_pkg.sv
// ----------------------------------------------------------------------------
// gzf_pkg: shared types and constants of the gzip framer
// Payload structs, configuration layout, command and register codes, and the
// byte-wide CRC-32 update used for the optional header check.
// ----------------------------------------------------------------------------
`default_nettype none

package gzf_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  field_byte;
    logic [31:0] data_crc;
    logic [31:0] input_size;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_done;
    logic       status;
  } out_t;

  typedef struct packed {
    logic [7:0]  header_flags;
    logic [31:0] modify_time;
    logic [7:0]  extra_flags;
    logic [7:0]  os_code;
    logic [15:0] extra_length;
  } cfg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // command codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_FIELD = 2'd1;
  localparam logic [1:0] FUNC_TRAIL = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FLAGS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODIFY_TIME  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_FLAGS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OS_CODE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_LENGTH = 3'd4;

  // FLG bit positions
  localparam int FLG_FHCRC    = 1;
  localparam int FLG_FEXTRA   = 2;
  localparam int FLG_FNAME    = 3;
  localparam int FLG_FCOMMENT = 4;

  localparam logic [7:0]  GZ_ID1 = 8'h1F;
  localparam logic [7:0]  GZ_ID2 = 8'h8B;
  localparam logic [7:0]  GZ_CM  = 8'h08;

  localparam logic [7:0]  OS_CODE_RESET = 8'hFF;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gzf_obuf.sv
// ----------------------------------------------------------------------------
// gzf_obuf: two-entry output buffer
// Holds result bytes so the sequencer keeps going while the sink stalls;
// its space flag is registered, so no ready path runs through the block.
// ----------------------------------------------------------------------------
`default_nettype none

module gzf_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gzf_pkg::out_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output gzf_pkg::out_t out_data
);

  gzf_pkg::out_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gzf_seq.sv
// ----------------------------------------------------------------------------
// gzf_seq: command register and byte sequencer
// Holds the accepted command and steps through its result bytes one per cycle
// with buffer space; keeps open section, header crc, remaining extra length.
// ----------------------------------------------------------------------------
`default_nettype none

module gzf_seq (
  input  logic          clk,
  input  logic          rst,
  input  gzf_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  gzf_pkg::in_t  in_data,
  input  logic          ob_space,
  output logic          ob_push,
  output gzf_pkg::out_t ob_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEAD, PH_FIELD, PH_HCRC_LO, PH_HCRC_HI, PH_TRAIL, PH_NOP
  } phase_t;

  typedef enum logic [1:0] {SEC_IDLE, SEC_EXTRA, SEC_NAME, SEC_COMMENT} sec_t;

  phase_t        phase, phase_next;
  logic [3:0]    idx, idx_next;
  gzf_pkg::in_t  job, job_next;
  sec_t          section, section_next;
  logic [31:0]   hdr_crc, hdr_crc_next;
  logic [15:0]   extra_remaining, extra_remaining_next;
  logic [7:0]    live_flags, live_flags_next;

  logic          adv;
  logic          job_last;
  logic          closes;
  sec_t          close_from;
  sec_t          nxt;
  logic [31:0]   crc_base;
  logic [63:0]   trail_word;
  logic [3:0]    last_hdr_idx;

  // first enabled section after the one being closed
  function automatic sec_t next_sec(input sec_t from, input logic [7:0] flags,
                                    input logic rem_nz);
    sec_t s;
    if (from == SEC_IDLE && flags[gzf_pkg::FLG_FEXTRA] && rem_nz) begin
      s = SEC_EXTRA;
    end else if ((from == SEC_IDLE || from == SEC_EXTRA) && flags[gzf_pkg::FLG_FNAME]) begin
      s = SEC_NAME;
    end else if (from != SEC_COMMENT && flags[gzf_pkg::FLG_FCOMMENT]) begin
      s = SEC_COMMENT;
    end else begin
      s = SEC_IDLE;
    end
    return s;
  endfunction

  assign adv          = ob_space && (phase != PH_IDLE);
  assign crc_base     = (idx == 4'd0) ? gzf_pkg::CRC_INIT : hdr_crc;
  assign trail_word   = {job.input_size, job.data_crc};
  assign last_hdr_idx = live_flags[gzf_pkg::FLG_FEXTRA] ? 4'd11 : 4'd9;
  assign nxt          = next_sec(close_from, live_flags, extra_remaining != 16'd0);

  always_comb begin
    phase_next           = phase;
    idx_next             = idx;
    job_next             = job;
    section_next         = section;
    hdr_crc_next         = hdr_crc;
    extra_remaining_next = extra_remaining;
    live_flags_next      = live_flags;
    ob_push              = 1'b0;
    ob_data              = '0;
    job_last             = 1'b0;
    closes               = 1'b0;
    close_from           = section;

    if (adv) begin
      case (phase)
        PH_HEAD: begin
          ob_push = 1'b1;
          case (idx)
            4'd0:    ob_data.out_byte = gzf_pkg::GZ_ID1;
            4'd1:    ob_data.out_byte = gzf_pkg::GZ_ID2;
            4'd2:    ob_data.out_byte = gzf_pkg::GZ_CM;
            4'd3:    ob_data.out_byte = live_flags;
            4'd4:    ob_data.out_byte = cfg.modify_time[7:0];
            4'd5:    ob_data.out_byte = cfg.modify_time[15:8];
            4'd6:    ob_data.out_byte = cfg.modify_time[23:16];
            4'd7:    ob_data.out_byte = cfg.modify_time[31:24];
            4'd8:    ob_data.out_byte = cfg.extra_flags;
            4'd9:    ob_data.out_byte = cfg.os_code;
            4'd10:   ob_data.out_byte = extra_remaining[7:0];
            4'd11:   ob_data.out_byte = extra_remaining[15:8];
            default: ob_data.out_byte = 8'd0;
          endcase
          hdr_crc_next = gzf_pkg::crc32_byte(crc_base, ob_data.out_byte);
          // flags and xlen are taken at the first header byte
          if (idx == 4'd0) begin
            live_flags_next      = cfg.header_flags;
            extra_remaining_next = cfg.header_flags[gzf_pkg::FLG_FEXTRA] ?
                                   cfg.extra_length : 16'd0;
          end
          if (idx == last_hdr_idx) begin
            closes     = 1'b1;
            close_from = SEC_IDLE;
          end else begin
            idx_next = idx + 4'd1;
          end
        end
        PH_FIELD: begin
          ob_push = 1'b1;
          if (section == SEC_IDLE) begin
            ob_data.status = 1'b1;
          end else begin
            ob_data.out_byte = job.field_byte;
            hdr_crc_next     = gzf_pkg::crc32_byte(hdr_crc, job.field_byte);
            if (section == SEC_EXTRA) begin
              extra_remaining_next = extra_remaining - 16'd1;
              closes = (extra_remaining == 16'd1);
            end else begin
              closes = (job.field_byte == 8'd0);
            end
          end
          if (!closes) begin
            job_last = 1'b1;
          end
        end
        PH_HCRC_LO: begin
          ob_push          = 1'b1;
          ob_data.out_byte = ~hdr_crc[7:0];
          phase_next       = PH_HCRC_HI;
        end
        PH_HCRC_HI: begin
          ob_push            = 1'b1;
          ob_data.out_byte   = ~hdr_crc[15:8];
          ob_data.frame_done = 1'b1;
          job_last           = 1'b1;
        end
        PH_TRAIL: begin
          ob_push            = 1'b1;
          section_next       = SEC_IDLE;
          ob_data.out_byte   = trail_word[idx[2:0]*8 +: 8];
          ob_data.frame_done = (idx[2:0] == 3'd7);
          job_last           = (idx[2:0] == 3'd7);
          idx_next           = idx + 4'd1;
        end
        PH_NOP: begin
          job_last = 1'b1;
        end
        default: begin
          job_last = 1'b1;
        end
      endcase

      if (closes) begin
        section_next = nxt;
        if (nxt == SEC_IDLE && live_flags[gzf_pkg::FLG_FHCRC]) begin
          phase_next = PH_HCRC_LO;
        end else begin
          job_last = 1'b1;
          if (nxt == SEC_IDLE) begin
            ob_data.frame_done = 1'b1;
          end
        end
      end

      if (job_last) begin
        phase_next = PH_IDLE;
      end
    end

    in_ready = (phase == PH_IDLE) || (adv && job_last);

    if (in_valid && in_ready) begin
      job_next = in_data;
      idx_next = 4'd0;
      case (in_data.func)
        gzf_pkg::FUNC_START: phase_next = PH_HEAD;
        gzf_pkg::FUNC_FIELD: phase_next = PH_FIELD;
        gzf_pkg::FUNC_TRAIL: phase_next = PH_TRAIL;
        default:             phase_next = PH_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      idx             <= 4'd0;
      section         <= SEC_IDLE;
      hdr_crc         <= gzf_pkg::CRC_INIT;
      extra_remaining <= 16'd0;
      live_flags      <= 8'd0;
    end else begin
      phase           <= phase_next;
      idx             <= idx_next;
      section         <= section_next;
      hdr_crc         <= hdr_crc_next;
      extra_remaining <= extra_remaining_next;
      live_flags      <= live_flags_next;
    end
    job <= job_next;
  end

endmodule

`default_nettype wire

FILE: rtl/gzip_header_trailer_framer_unit.sv
// ----------------------------------------------------------------------------
// gzip_header_trailer_framer_unit: gzip member header and trailer writer
// Turns start, field-byte and trailer commands into the framing bytes of a
// gzip member, with the optional header crc.
// ----------------------------------------------------------------------------
// The block sends one framing byte per cycle on the output channel while the
// buffer has space. A field byte gives its byte, and the header crc when it
// closes the last section with FHCRC set; a start the header, with XLEN if
// FEXTRA and the crc if FHCRC and no section follows; a trailer the crc and
// size words; an unused command code nothing. A new command is taken in the
// cycle its predecessor sends its last byte, so field bytes run at one per
// cycle while the buffer has space. A two-entry output buffer decouples the
// sink, so a stalled sink holds the input only once the buffer is full.
// Configuration writes land at once and should be made while no command is
// in flight; the flags and extra length are captured when a header starts.
`default_nettype none

module gzip_header_trailer_framer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gzf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gzf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gzf_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gzf_pkg::out_t                     out_data
);

  gzf_pkg::cfg_t cfg;
  logic          ob_space;
  logic          ob_push;
  gzf_pkg::out_t ob_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_flags <= 8'd0;
      cfg.modify_time  <= 32'd0;
      cfg.extra_flags  <= 8'd0;
      cfg.os_code      <= gzf_pkg::OS_CODE_RESET;
      cfg.extra_length <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        gzf_pkg::REG_HEADER_FLAGS: cfg.header_flags <= cfg_data[7:0];
        gzf_pkg::REG_MODIFY_TIME:  cfg.modify_time  <= cfg_data;
        gzf_pkg::REG_EXTRA_FLAGS:  cfg.extra_flags  <= cfg_data[7:0];
        gzf_pkg::REG_OS_CODE:      cfg.os_code      <= cfg_data[7:0];
        gzf_pkg::REG_EXTRA_LENGTH: cfg.extra_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gzf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ob_space (ob_space),
    .ob_push  (ob_push),
    .ob_data  (ob_data)
  );

  gzf_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (ob_push),
    .push_data (ob_data),
    .space     (ob_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/gzf_checker.sv
// ----------------------------------------------------------------------------
// gzf_checker: port-level checks for the gzip framer
// Watches the command and byte channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gzf_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input gzf_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input gzf_pkg::out_t out_data
);

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // a dropped-byte flag carries a zero byte and never closes a frame
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.out_byte == 8'd0 && !out_data.frame_done)
    else $error("status transfer with byte or frame end");

  // start and trailer span several output bytes, so the input is held next cycle
  a_multi_byte_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (in_data.func == gzf_pkg::FUNC_START || in_data.func == gzf_pkg::FUNC_TRAIL)
    |=> !in_ready)
    else $error("input taken during a header or trailer burst");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

endmodule

bind gzip_header_trailer_framer_unit gzf_checker u_gzf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
